[design/rwlm_pkg.sv]
`default_nettype none
package rwlm_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 8;

    localparam int ACT_W  = 3;
    localparam int TIDF_W = 8;   // thread id field width on the ports
    localparam int KIND_W = 4;
    localparam int RC_W   = 10;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RC_W-1:0]  RD_MAX    = {RC_W{1'b1}};
    localparam logic [CNT_W-1:0] Q_FULL    = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [ACT_W-1:0] ACT_RD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TRY_RD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WR     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TRY_WR = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UNLOCK = 3'd4;

    localparam logic [KIND_W-1:0] K_GRANTED   = 4'd0;
    localparam logic [KIND_W-1:0] K_QUEUED    = 4'd1;
    localparam logic [KIND_W-1:0] K_REFUSED   = 4'd2;
    localparam logic [KIND_W-1:0] K_RELEASED  = 4'd3;
    localparam logic [KIND_W-1:0] K_RD_WOKEN  = 4'd4;
    localparam logic [KIND_W-1:0] K_WR_WOKEN  = 4'd5;
    localparam logic [KIND_W-1:0] K_FULL      = 4'd6;
    localparam logic [KIND_W-1:0] K_NO_HOLDER = 4'd7;
    localparam logic [KIND_W-1:0] K_OVERFLOW  = 4'd8;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIDF_W-1:0] thread_id;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIDF_W-1:0] thread_id_res;
        logic              last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic wake_wr;
        logic wake_rd;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic phase_wr;
        logic phase_rd;
        logic rd_last;
    } t_status;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // (head + count) mod depth; the sum stays below twice the depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] h,
                                                 input logic [CNT_W-1:0] c);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(h) + (CNT_W+1)'(c);
        if (s >= (CNT_W+1)'(QUEUE_DEPTH)) s = s - (CNT_W+1)'(QUEUE_DEPTH);
        ptr_add = s[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

[design/rwlm_ctrl.sv]
`default_nettype none
module rwlm_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  rwlm_pkg::t_status i_status,
    output rwlm_pkg::t_cmd   o_cmd
);
    import rwlm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EXEC    = 4'b0010,
        S_WAKE_WR = 4'b0100,
        S_WAKE_RD = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_stall   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_status.phase_wr)      n_state = S_WAKE_WR;
                    else if (i_status.phase_rd) n_state = S_WAKE_RD;
                    else                        n_state = S_IDLE;
                end
            end
            S_WAKE_WR: begin
                if (i_status.out_free) begin
                    o_cmd.wake_wr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_WAKE_RD: begin
                if (i_status.out_free) begin
                    o_cmd.wake_rd = 1'b1;
                    if (i_status.rd_last) n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/rwlm_dp.sv]
`default_nettype none
module rwlm_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rwlm_pkg::t_in     i_item,
    input  wire               i_stall,
    output logic              o_valid,
    output rwlm_pkg::t_out    o_item,
    input  rwlm_pkg::t_cmd    i_cmd,
    output rwlm_pkg::t_status o_status
);
    import rwlm_pkg::*;

    localparam int TID_W = THREAD_ID_BITS;

    // wait queues
    logic [TID_W-1:0] r_rq_mem [QUEUE_DEPTH];
    logic [TID_W-1:0] r_wq_mem [QUEUE_DEPTH];
    logic [TID_W-1:0] r_rq_data, r_wq_data;

    logic [PTR_W-1:0] r_rq_head, n_rq_head, r_wq_head, n_wq_head;
    logic [CNT_W-1:0] r_rq_cnt, n_rq_cnt, r_wq_cnt, n_wq_cnt;
    logic [RC_W-1:0]  r_rd_cnt, n_rd_cnt;
    logic             r_wr_held, n_wr_held;

    t_in              r_req;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic             rq_push, wq_push, rq_pop, wq_pop;
    logic [TID_W-1:0] tid;
    logic             out_free, unlock, phase_wr, phase_rd;

    assign tid      = r_req.thread_id[TID_W-1:0];
    assign out_free = !r_out_valid || !i_stall;
    assign unlock   = (r_req.action == ACT_UNLOCK);
    assign phase_wr = unlock && (r_wq_cnt != '0) &&
                      (r_wr_held || (r_rd_cnt == RC_W'(1)));
    assign phase_rd = unlock && r_wr_held && (r_wq_cnt == '0) && (r_rq_cnt != '0);

    assign o_status.out_free = out_free;
    assign o_status.phase_wr = phase_wr;
    assign o_status.phase_rd = phase_rd;
    assign o_status.rd_last  = (r_rq_cnt == CNT_W'(1));

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_rq_head   = r_rq_head;
        n_wq_head   = r_wq_head;
        n_rq_cnt    = r_rq_cnt;
        n_wq_cnt    = r_wq_cnt;
        n_rd_cnt    = r_rd_cnt;
        n_wr_held   = r_wr_held;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        rq_push     = 1'b0;
        wq_push     = 1'b0;
        rq_pop      = 1'b0;
        wq_pop      = 1'b0;

        if (i_cmd.exec) begin
            n_out_valid         = 1'b1;
            n_out.thread_id_res = TIDF_W'(tid);
            n_out.last          = !(phase_wr || phase_rd);
            case (r_req.action)
                ACT_RD, ACT_TRY_RD: begin
                    if (!r_wr_held) begin
                        if (r_rd_cnt == RD_MAX) begin
                            n_out.kind = K_OVERFLOW;
                        end else begin
                            n_rd_cnt   = r_rd_cnt + 1'b1;
                            n_out.kind = K_GRANTED;
                        end
                    end else if (r_req.action == ACT_TRY_RD) begin
                        n_out.kind = K_REFUSED;
                    end else if (r_rq_cnt == Q_FULL) begin
                        n_out.kind = K_FULL;
                    end else begin
                        rq_push    = 1'b1;
                        n_rq_cnt   = r_rq_cnt + 1'b1;
                        n_out.kind = K_QUEUED;
                    end
                end
                ACT_WR, ACT_TRY_WR: begin
                    if (!r_wr_held && r_rd_cnt == '0) begin
                        n_wr_held  = 1'b1;
                        n_out.kind = K_GRANTED;
                    end else if (r_req.action == ACT_TRY_WR) begin
                        n_out.kind = K_REFUSED;
                    end else if (r_wq_cnt == Q_FULL) begin
                        n_out.kind = K_FULL;
                    end else begin
                        wq_push    = 1'b1;
                        n_wq_cnt   = r_wq_cnt + 1'b1;
                        n_out.kind = K_QUEUED;
                    end
                end
                ACT_UNLOCK: begin
                    if (r_wr_held) begin
                        n_out.kind = K_RELEASED;
                        if (r_wq_cnt == '0) n_wr_held = 1'b0;
                    end else if (r_rd_cnt == '0) begin
                        n_out.kind = K_NO_HOLDER;
                    end else begin
                        n_rd_cnt   = r_rd_cnt - 1'b1;
                        n_out.kind = K_RELEASED;
                        if (phase_wr) n_wr_held = 1'b1;
                    end
                end
                default: begin
                    // unknown action: no transaction out
                    n_out_valid = r_out_valid && i_stall;
                end
            endcase
        end

        if (i_cmd.wake_wr) begin
            wq_pop              = 1'b1;
            n_wq_head           = ptr_inc(r_wq_head);
            n_wq_cnt            = r_wq_cnt - 1'b1;
            n_wr_held           = 1'b1;
            n_out_valid         = 1'b1;
            n_out.kind          = K_WR_WOKEN;
            n_out.thread_id_res = TIDF_W'(r_wq_data);
            n_out.last          = 1'b1;
        end

        if (i_cmd.wake_rd) begin
            rq_pop              = 1'b1;
            n_rq_head           = ptr_inc(r_rq_head);
            n_rq_cnt            = r_rq_cnt - 1'b1;
            if (r_rd_cnt != RD_MAX) n_rd_cnt = r_rd_cnt + 1'b1;
            n_out_valid         = 1'b1;
            n_out.kind          = K_RD_WOKEN;
            n_out.thread_id_res = TIDF_W'(r_rq_data);
            n_out.last          = (r_rq_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_head   <= '0;
            r_wq_head   <= '0;
            r_rq_cnt    <= '0;
            r_wq_cnt    <= '0;
            r_rd_cnt    <= '0;
            r_wr_held   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rq_head   <= n_rq_head;
            r_wq_head   <= n_wq_head;
            r_rq_cnt    <= n_rq_cnt;
            r_wq_cnt    <= n_wq_cnt;
            r_rd_cnt    <= n_rd_cnt;
            r_wr_held   <= n_wr_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.load) r_req <= i_item;
    end

    // queue writes at the tail
    always_ff @(posedge i_clk) begin
        if (rq_push) r_rq_mem[ptr_add(r_rq_head, r_rq_cnt)] <= tid;
        if (wq_push) r_wq_mem[ptr_add(r_wq_head, r_wq_cnt)] <= tid;
    end

    // registered head read; on a pop the next entry is fetched so a burst of
    // wakes runs one per cycle unless stalled. A push lands before its pop.
    always_ff @(posedge i_clk) begin
        r_rq_data <= r_rq_mem[rq_pop ? ptr_inc(r_rq_head) : r_rq_head];
        r_wq_data <= r_wq_mem[wq_pop ? ptr_inc(r_wq_head) : r_wq_head];
    end

endmodule
`default_nettype wire

[design/reader_writer_lock_manager.sv]
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_item  (action, thread_id)
// result    out        o_valid / i_stall   o_item  (kind, thread_id_res, last)
//
// A request is handled in order: capture, then a decision step that loads
// the result register, then one wake step for each wake result (woken writer,
// or each woken reader in queue order), up to QUEUE_DEPTH wakes, in the
// sequence set by the controller.
// Stalls on the result side hold the block in place; a new request can be
// captured while the last result of the previous one still waits.
// Reset is synchronous, active low; queues come up empty.
`default_nettype none
module reader_writer_lock_manager (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  rwlm_pkg::t_in  i_item,
    output logic           o_valid,
    input  wire            i_stall,
    output rwlm_pkg::t_out o_item
);
    import rwlm_pkg::*;

    t_cmd    cmd;
    t_status status;

    rwlm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rwlm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_item   (o_item),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule
`default_nettype wire

[design/rwlm_checker.sv]
`default_nettype none
module rwlm_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_valid,
    input wire            o_stall,
    input rwlm_pkg::t_in  i_item,
    input wire            o_valid,
    input wire            i_stall,
    input rwlm_pkg::t_out o_item
);
    import rwlm_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled result changed");

    // one request at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while busy");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.kind <= K_OVERFLOW))
        else $error("bad result kind");

    // single-result replies and writer wakes always end their burst
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.kind == K_GRANTED || o_item.kind == K_QUEUED ||
                     o_item.kind == K_REFUSED || o_item.kind == K_FULL ||
                     o_item.kind == K_NO_HOLDER || o_item.kind == K_OVERFLOW ||
                     o_item.kind == K_WR_WOKEN)) |-> o_item.last)
        else $error("single result without last");

    // a request cannot be taken while a multi-result burst is mid-flight
    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_item.last) |-> o_stall)
        else $error("request accepted mid-burst");

endmodule

bind reader_writer_lock_manager rwlm_checker u_rwlm_checker (.*);
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

import rwlm_pkg::*;

// Tracks lock state and the result transactions each request should produce.
class lock_scoreboard;
    logic [RC_W-1:0]   readers;
    logic              writer_held;
    logic [TIDF_W-1:0] rd_waiters[$];
    logic [TIDF_W-1:0] wr_waiters[$];
    t_out              expected[$];
    int                errors;

    function new();
        readers     = '0;
        writer_held = 1'b0;
        errors      = 0;
    endfunction

    function t_out reply(logic [KIND_W-1:0] kind, logic [TIDF_W-1:0] tid);
        t_out r;
        r.kind          = kind;
        r.thread_id_res = tid;
        r.last          = 1'b0;
        return r;
    endfunction

    function void note_request(t_in req);
        t_out              replies[$];
        t_out              r;
        logic [TIDF_W-1:0] tid;
        tid = req.thread_id & TIDF_W'((1 << THREAD_ID_BITS) - 1);
        case (req.action)
            ACT_RD, ACT_TRY_RD: begin
                if (!writer_held) begin
                    if (readers >= RD_MAX) begin
                        replies.push_back(reply(K_OVERFLOW, tid));
                    end else begin
                        readers = readers + 1'b1;
                        replies.push_back(reply(K_GRANTED, tid));
                    end
                end else if (req.action == ACT_TRY_RD) begin
                    replies.push_back(reply(K_REFUSED, tid));
                end else if (rd_waiters.size() >= QUEUE_DEPTH) begin
                    replies.push_back(reply(K_FULL, tid));
                end else begin
                    rd_waiters.push_back(tid);
                    replies.push_back(reply(K_QUEUED, tid));
                end
            end
            ACT_WR, ACT_TRY_WR: begin
                if (!writer_held && readers == '0) begin
                    writer_held = 1'b1;
                    replies.push_back(reply(K_GRANTED, tid));
                end else if (req.action == ACT_TRY_WR) begin
                    replies.push_back(reply(K_REFUSED, tid));
                end else if (wr_waiters.size() >= QUEUE_DEPTH) begin
                    replies.push_back(reply(K_FULL, tid));
                end else begin
                    wr_waiters.push_back(tid);
                    replies.push_back(reply(K_QUEUED, tid));
                end
            end
            ACT_UNLOCK: begin
                if (writer_held) begin
                    replies.push_back(reply(K_RELEASED, tid));
                    if (wr_waiters.size() > 0) begin
                        replies.push_back(reply(K_WR_WOKEN, wr_waiters.pop_front()));
                    end else begin
                        // writer leaves: every queued reader becomes a holder
                        writer_held = 1'b0;
                        while (rd_waiters.size() > 0) begin
                            if (readers < RD_MAX) readers = readers + 1'b1;
                            replies.push_back(reply(K_RD_WOKEN, rd_waiters.pop_front()));
                        end
                    end
                end else if (readers == '0) begin
                    replies.push_back(reply(K_NO_HOLDER, tid));
                end else begin
                    readers = readers - 1'b1;
                    replies.push_back(reply(K_RELEASED, tid));
                    if (readers == '0 && wr_waiters.size() > 0) begin
                        writer_held = 1'b1;
                        replies.push_back(reply(K_WR_WOKEN, wr_waiters.pop_front()));
                    end
                end
            end
            default: ;
        endcase
        foreach (replies[i]) begin
            r      = replies[i];
            r.last = (i == replies.size() - 1);
            expected.push_back(r);
        end
    endfunction

    function void check_result(t_out got);
        t_out want;
        if (expected.size() == 0) begin
            $error("unexpected result: kind %0d thread_id_res %0h last %0b",
                   got.kind, got.thread_id_res, got.last);
            errors++;
            return;
        end
        want = expected.pop_front();
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            errors++;
        end
        if (got.thread_id_res !== want.thread_id_res) begin
            $error("thread_id_res: expected %0h, actual %0h",
                   want.thread_id_res, got.thread_id_res);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int          RANDOM_ITEMS = 200;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_item;
    logic o_valid;
    logic i_stall;
    t_out o_item;

    lock_scoreboard sb;
    int unsigned    cycles     = 0;
    int unsigned    lock_reqs  = 0;
    int             burst_left = 1;

    reader_writer_lock_manager uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("reader_writer_lock_manager verification failed");
            $finish;
        end
    end

    // Request first: a result never leaves in the cycle its request is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_item);
            if (o_valid && !i_stall) sb.check_result(o_item);
        end
    end

    // Result-side backpressure: stretches of fixed stall density, zero included.
    initial begin
        int span;
        int pct;
        i_stall = 1'b0;
        span    = 0;
        pct     = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                span = $urandom_range(20, 100);
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 20;
                    2:       pct = 50;
                    default: pct = 85;
                endcase
            end
            span--;
            i_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    function automatic logic [TIDF_W-1:0] any_tid();
        return TIDF_W'($urandom_range(0, (1 << TIDF_W) - 1));
    endfunction

    function automatic logic [ACT_W-1:0] bad_action();
        return ACT_W'($urandom_range(int'(ACT_UNLOCK) + 1, (1 << ACT_W) - 1));
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 22) return ACT_RD;
        else if (roll < 34) return ACT_TRY_RD;
        else if (roll < 54) return ACT_WR;
        else if (roll < 64) return ACT_TRY_WR;
        else if (roll < 94) return ACT_UNLOCK;
        else return bad_action();
    endfunction

    function automatic logic [ACT_W-1:0] pick_read();
        return ($urandom_range(0, 3) == 0) ? ACT_TRY_RD : ACT_RD;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high
    // unless a gap between bursts was taken.
    task automatic request(input logic [ACT_W-1:0] act, input logic [TIDF_W-1:0] tid);
        int gap;
        i_item  <= {act, tid};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (act <= ACT_UNLOCK) lock_reqs++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    initial begin
        int          n;
        int unsigned rand_start;

        sb      = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: each operation, each kind bar full and overflow, id extremes
        request(ACT_UNLOCK, 8'h00);
        request(ACT_RD,     8'hFF);
        request(ACT_TRY_RD, 8'h00);
        request(ACT_TRY_WR, 8'h55);
        request(ACT_WR,     8'hAA);
        request(ACT_UNLOCK, 8'hFF);
        request(ACT_UNLOCK, 8'h00);
        request(ACT_RD,     8'h01);
        request(ACT_TRY_RD, 8'h02);
        request(ACT_WR,     8'h03);
        request(ACT_TRY_WR, 8'h04);
        request(ACT_UNLOCK, 8'hAA);
        request(ACT_UNLOCK, 8'h03);
        for (int a = int'(ACT_UNLOCK) + 1; a < (1 << ACT_W); a++)
            request(ACT_W'(a), any_tid());
        request(ACT_UNLOCK, 8'h01);
        request(ACT_TRY_WR, 8'h7F);
        request(ACT_RD,     8'h80);
        request(ACT_RD,     8'h81);
        request(ACT_UNLOCK, 8'h7F);
        request(ACT_UNLOCK, 8'h80);
        request(ACT_UNLOCK, 8'h81);
        request(ACT_UNLOCK, 8'hFF);

        // both wait queues up to full and one past, then drain through handoffs;
        // the last writer unlock wakes a full reader queue
        request(ACT_WR, 8'hC3);
        for (int i = 0; i <= QUEUE_DEPTH; i++) request(ACT_RD, TIDF_W'(i));
        for (int i = 0; i <= QUEUE_DEPTH; i++) request(ACT_WR, TIDF_W'(8'h80 + i));
        repeat (QUEUE_DEPTH + 1) request(ACT_UNLOCK, any_tid());
        repeat (QUEUE_DEPTH) request(ACT_UNLOCK, any_tid());

        rand_start = lock_reqs;
        while (lock_reqs < rand_start + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(4, 16)) request(pick_action(), any_tid());
                end
                4, 5: begin
                    // writer holds while readers pile up, then lets them in
                    request(ACT_WR, any_tid());
                    repeat ($urandom_range(0, QUEUE_DEPTH + 2))
                        request(pick_read(), any_tid());
                    repeat ($urandom_range(1, 3)) request(ACT_UNLOCK, any_tid());
                end
                6, 7: begin
                    // readers hold while writers queue behind them
                    n = $urandom_range(1, 6);
                    repeat (n) request(pick_read(), any_tid());
                    repeat ($urandom_range(0, QUEUE_DEPTH + 2))
                        request(($urandom_range(0, 4) == 0) ? ACT_TRY_WR : ACT_WR,
                                any_tid());
                    repeat (n + $urandom_range(0, 6)) request(ACT_UNLOCK, any_tid());
                end
                8: begin
                    repeat ($urandom_range(2, QUEUE_DEPTH + 2)) request(ACT_WR, any_tid());
                    repeat ($urandom_range(1, QUEUE_DEPTH + 2))
                        request(ACT_UNLOCK, any_tid());
                end
                default: begin
                    repeat ($urandom_range(1, 4)) request(bad_action(), any_tid());
                    request(ACT_UNLOCK, any_tid());
                end
            endcase
        end

        i_valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (2 * QUEUE_DEPTH + 8) @(posedge i_clk);
        @(negedge i_clk);
        if (sb.expected.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("reader_writer_lock_manager verification clean");
        end else begin
            $display("reader_writer_lock_manager verification failed");
        end
        $finish;
    end
endmodule
